/* src/ehct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ehct_pkg: shared types and constants for the Ethernet header classifier
// Frame and result payload layouts, class and protocol codes, EtherType
// values, table sizing and the saturating increment helpers.
// ----------------------------------------------------------------------------
package ehct_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int MAX_FRAME     = 2048;
	localparam int TALLY_WIDTH   = 16;
	localparam int COUNTER_WIDTH = 32;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int MAC_W = 48;
	localparam int LEN_W = 12;
	localparam int PAY_W = 11;

	localparam logic [LEN_W-1:0] HEADER_BYTES = 12'd14;

	localparam logic [15:0] ETH2_MIN_TYPE = 16'h0600;
	localparam logic [15:0] LEN_MAX_TYPE  = 16'h05DC;
	localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
	localparam logic [15:0] ETYPE_ARP     = 16'h0806;
	localparam logic [15:0] ETYPE_FLOW    = 16'h8808;
	localparam logic [15:0] ETYPE_MACSEC  = 16'h88E5;

	typedef enum logic [1:0] {
		CLASS_SHORT = 2'd0,
		CLASS_ETH2  = 2'd1,
		CLASS_8023  = 2'd2,
		CLASS_OTHER = 2'd3
	} frame_class_t;

	typedef enum logic [2:0] {
		PROTO_IPV4   = 3'd0,
		PROTO_IPV6   = 3'd1,
		PROTO_ARP    = 3'd2,
		PROTO_FLOW   = 3'd3,
		PROTO_MACSEC = 3'd4,
		PROTO_NONE   = 3'd5
	} protocol_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_SCAN,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0] frame_length;
		logic [MAC_W-1:0] dest_mac;
		logic [MAC_W-1:0] source_mac;
		logic [15:0]      ether_type;
	} frame_t;

	typedef struct packed {
		logic [1:0]               frame_class;
		logic [2:0]               protocol_kind;
		logic [PAY_W-1:0]         payload_length;
		logic                     src_multicast;
		logic                     dst_multicast;
		logic [COUNTER_WIDTH-1:0] total_count;
		logic [COUNTER_WIDTH-1:0] class_count;
		logic [COUNTER_WIDTH-1:0] protocol_count;
		logic [TALLY_WIDTH-1:0]   src_tally;
		logic [TALLY_WIDTH-1:0]   dst_tally;
		logic                     table_full;
	} result_t;

	function automatic logic [COUNTER_WIDTH-1:0] bump_count(
		input logic [COUNTER_WIDTH-1:0] v
	);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [TALLY_WIDTH-1:0] bump_tally(
		input logic [TALLY_WIDTH-1:0] v
	);
		return (&v) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

/* src/ehct_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ehct interfaces: valid/ready channels for frame headers and results
// Each channel carries valid, ready and one payload struct.
// ----------------------------------------------------------------------------
interface ehct_frame_if;
	logic             valid;
	logic             ready;
	ehct_pkg::frame_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ehct_result_if;
	logic              valid;
	logic              ready;
	ehct_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/ethernet_header_classifier_tally.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_header_classifier_tally: frame classifier with MAC statistics
// Classifies each frame header, bumps saturating frame/class/protocol
// counters and tallies source then destination MAC in an address table.
// ----------------------------------------------------------------------------
// A frame that is not Ethernet II passes from IDLE through CLASSIFY to FINISH,
// where its result is loaded into the output register. Ethernet II frames scan
// the entries in use twice, source then destination, with one shared 48-bit
// comparator. Frames are accepted only in IDLE, one at a time; a new frame is
// accepted while the previous result waits.
// Reset clears all counters and the fill count; table contents need no clear.
module ethernet_header_classifier_tally (
	input  wire logic           clk,
	input  wire logic           arst_n,
	ehct_frame_if.sink          frames,
	ehct_result_if.source       results
);

	ehct_pkg::state_t state_q, state_d;

	ehct_pkg::frame_t  in_q;
	ehct_pkg::result_t res_q;
	ehct_pkg::result_t out_q;
	logic              out_valid_q;

	logic [ehct_pkg::COUNTER_WIDTH-1:0] total_q;
	logic [ehct_pkg::COUNTER_WIDTH-1:0] class_cnt_q [3];
	logic [ehct_pkg::COUNTER_WIDTH-1:0] proto_cnt_q [5];

	logic [ehct_pkg::MAC_W-1:0]       address_store   [ehct_pkg::TABLE_ENTRIES];
	logic [ehct_pkg::TALLY_WIDTH-1:0] address_tallies [ehct_pkg::TABLE_ENTRIES];

	logic [ehct_pkg::CNT_W-1:0]       used_q;
	logic [ehct_pkg::CNT_W-1:0]       rd_idx_q;
	logic                             pend_s1;
	logic [ehct_pkg::IDX_W-1:0]       pend_idx_s1;
	logic [ehct_pkg::MAC_W-1:0]       store_rd_s1;
	logic [ehct_pkg::TALLY_WIDTH-1:0] tally_rd_s1;
	logic [ehct_pkg::MAC_W-1:0]       mac_q;
	logic                             side_dst_q;
	logic                             hit_q;
	logic [ehct_pkg::IDX_W-1:0]       hit_idx_q;
	logic [ehct_pkg::TALLY_WIDTH-1:0] tally_q;

	// classification of the latched header
	logic [ehct_pkg::LEN_W-1:0]         len_sat;
	logic [ehct_pkg::LEN_W-1:0]         len_diff;
	logic                               is_long;
	logic [1:0]                         cls;
	logic [1:0]                         ci;
	logic [2:0]                         pk;
	logic [ehct_pkg::PAY_W-1:0]         payload;
	logic [ehct_pkg::COUNTER_WIDTH-1:0] total_new;
	logic [ehct_pkg::COUNTER_WIDTH-1:0] class_new;
	logic [ehct_pkg::COUNTER_WIDTH-1:0] proto_new;
	ehct_pkg::result_t                  res_class;

	// sequencer controls
	logic                             accept;
	logic                             issue;
	logic                             scan_hit;
	logic                             scan_miss;
	logic                             room;
	logic                             tally_we;
	logic                             store_we;
	logic [ehct_pkg::IDX_W-1:0]       wr_idx;
	logic [ehct_pkg::TALLY_WIDTH-1:0] new_tally;
	logic                             miss_full;
	logic                             out_load;

	always_comb begin
		if (int'(in_q.frame_length) > ehct_pkg::MAX_FRAME) begin
			len_sat = ehct_pkg::LEN_W'(ehct_pkg::MAX_FRAME);
		end else begin
			len_sat = in_q.frame_length;
		end
		is_long  = len_sat > ehct_pkg::HEADER_BYTES;
		len_diff = len_sat - ehct_pkg::HEADER_BYTES;

		if (!is_long) begin
			cls = ehct_pkg::CLASS_SHORT;
		end else if (in_q.ether_type >= ehct_pkg::ETH2_MIN_TYPE) begin
			cls = ehct_pkg::CLASS_ETH2;
		end else if (in_q.ether_type <= ehct_pkg::LEN_MAX_TYPE) begin
			cls = ehct_pkg::CLASS_8023;
		end else begin
			cls = ehct_pkg::CLASS_OTHER;
		end
		ci = cls - 2'd1;

		pk = ehct_pkg::PROTO_NONE;
		if (cls == ehct_pkg::CLASS_ETH2) begin
			case (in_q.ether_type)
				ehct_pkg::ETYPE_IPV4:   pk = ehct_pkg::PROTO_IPV4;
				ehct_pkg::ETYPE_IPV6:   pk = ehct_pkg::PROTO_IPV6;
				ehct_pkg::ETYPE_ARP:    pk = ehct_pkg::PROTO_ARP;
				ehct_pkg::ETYPE_FLOW:   pk = ehct_pkg::PROTO_FLOW;
				ehct_pkg::ETYPE_MACSEC: pk = ehct_pkg::PROTO_MACSEC;
				default:                pk = ehct_pkg::PROTO_NONE;
			endcase
		end

		if (len_diff > ehct_pkg::LEN_W'(2 ** ehct_pkg::PAY_W - 1)) begin
			payload = '1;
		end else begin
			payload = len_diff[ehct_pkg::PAY_W-1:0];
		end

		total_new = ehct_pkg::bump_count(total_q);
		class_new = ehct_pkg::bump_count(class_cnt_q[ci]);
		proto_new = '0;
		if (pk != ehct_pkg::PROTO_NONE) begin
			proto_new = ehct_pkg::bump_count(proto_cnt_q[pk]);
		end

		res_class                = '0;
		res_class.frame_class    = cls;
		res_class.protocol_kind  = pk;
		res_class.total_count    = total_new;
		if (cls != ehct_pkg::CLASS_SHORT) begin
			res_class.class_count = class_new;
		end
		res_class.protocol_count = proto_new;
		if (cls == ehct_pkg::CLASS_ETH2) begin
			res_class.payload_length = payload;
			res_class.src_multicast  = in_q.source_mac[40];
			res_class.dst_multicast  = in_q.dest_mac[40];
		end
	end

	// table lookup: one entry issued per cycle, compare on registered read data
	always_comb begin
		issue     = rd_idx_q < used_q;
		scan_hit  = pend_s1 && (store_rd_s1 == mac_q);
		scan_miss = !pend_s1 && !issue;
		room      = used_q < ehct_pkg::CNT_W'(ehct_pkg::TABLE_ENTRIES);
		miss_full = !hit_q && !room;
		if (hit_q) begin
			new_tally = ehct_pkg::bump_tally(tally_q);
			wr_idx    = hit_idx_q;
		end else begin
			new_tally = room ? ehct_pkg::TALLY_WIDTH'(1) : '0;
			wr_idx    = used_q[ehct_pkg::IDX_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ehct_pkg::ST_IDLE: begin
				if (frames.valid) state_d = ehct_pkg::ST_CLASSIFY;
			end
			ehct_pkg::ST_CLASSIFY: begin
				if (cls == ehct_pkg::CLASS_ETH2) state_d = ehct_pkg::ST_SCAN;
				else                             state_d = ehct_pkg::ST_FINISH;
			end
			ehct_pkg::ST_SCAN: begin
				if (scan_hit || scan_miss) state_d = ehct_pkg::ST_UPDATE;
			end
			ehct_pkg::ST_UPDATE: begin
				if (side_dst_q) state_d = ehct_pkg::ST_FINISH;
				else            state_d = ehct_pkg::ST_SCAN;
			end
			ehct_pkg::ST_FINISH: begin
				if (!out_valid_q || results.ready) state_d = ehct_pkg::ST_IDLE;
			end
			default: state_d = ehct_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		frames.ready = state_q == ehct_pkg::ST_IDLE;
		accept       = frames.valid && frames.ready;
		tally_we     = (state_q == ehct_pkg::ST_UPDATE) && (hit_q || room);
		store_we     = (state_q == ehct_pkg::ST_UPDATE) && !hit_q && room;
		out_load     = (state_q == ehct_pkg::ST_FINISH) && (!out_valid_q || results.ready);
		results.valid = out_valid_q;
		results.data  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ehct_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			class_cnt_q <= '{default: '0};
			proto_cnt_q <= '{default: '0};
			used_q      <= '0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			side_dst_q  <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load)                out_valid_q <= 1'b1;
			else if (results.ready)      out_valid_q <= 1'b0;

			if (state_q == ehct_pkg::ST_CLASSIFY) begin
				total_q <= total_new;
				if (cls != ehct_pkg::CLASS_SHORT) class_cnt_q[ci] <= class_new;
				if (pk != ehct_pkg::PROTO_NONE)   proto_cnt_q[pk] <= proto_new;
				side_dst_q <= 1'b0;
			end

			case (state_q)
				ehct_pkg::ST_SCAN: begin
					pend_s1 <= issue;
					if (issue) rd_idx_q <= rd_idx_q + 1'b1;
					hit_q <= scan_hit;
				end
				ehct_pkg::ST_UPDATE: begin
					if (store_we) used_q <= used_q + 1'b1;
					side_dst_q <= 1'b1;
					rd_idx_q   <= '0;
					pend_s1    <= 1'b0;
				end
				default: begin
					rd_idx_q <= '0;
					pend_s1  <= 1'b0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) in_q <= frames.data;
		if (out_load) out_q <= res_q;

		case (state_q)
			ehct_pkg::ST_CLASSIFY: begin
				res_q <= res_class;
				mac_q <= in_q.source_mac;
			end
			ehct_pkg::ST_SCAN: begin
				pend_idx_s1 <= rd_idx_q[ehct_pkg::IDX_W-1:0];
				hit_idx_q   <= pend_idx_s1;
				tally_q     <= tally_rd_s1;
			end
			ehct_pkg::ST_UPDATE: begin
				// source result first, then switch the comparator to the destination
				if (side_dst_q) res_q.dst_tally <= new_tally;
				else            res_q.src_tally <= new_tally;
				res_q.table_full <= res_q.table_full | miss_full;
				mac_q <= in_q.dest_mac;
			end
			default: begin
			end
		endcase
	end

	// address table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store_we) address_store[wr_idx] <= mac_q;
		if (tally_we) address_tallies[wr_idx] <= new_tally;
		store_rd_s1 <= address_store[rd_idx_q[ehct_pkg::IDX_W-1:0]];
		tally_rd_s1 <= address_tallies[rd_idx_q[ehct_pkg::IDX_W-1:0]];
	end

	a_accept_classify: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.ready |=> state_q == ehct_pkg::ST_CLASSIFY)
		else $error("accepted request did not enter classification");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= ehct_pkg::CNT_W'(ehct_pkg::TABLE_ENTRIES))
		else $error("address table fill count overflow");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.table_full |->
		used_q == ehct_pkg::CNT_W'(ehct_pkg::TABLE_ENTRIES))
		else $error("table_full reported with free entries");

	a_non_eth2_no_tally: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.frame_class != ehct_pkg::CLASS_ETH2 |->
		results.data.src_tally == '0 && results.data.dst_tally == '0 &&
		!results.data.table_full)
		else $error("address tally on a frame that is not Ethernet II");

endmodule
`default_nettype wire

/* test/tb_ethernet_header_classifier_tally.sv */
// ----------------------------------------------------------------------------
// tb_ethernet_header_classifier_tally: frame classifier and MAC tally check
// Drives frame headers over the request channel with random gaps, tracks the
// counters and address table in a local predictor, and compares every result
// field with the prediction. Directed headers hit the length and type
// boundaries and each protocol. Random traffic then reuses a small address
// pool so tallies grow and the table fills and overflows.
// ----------------------------------------------------------------------------
module tb_ethernet_header_classifier_tally;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          POOL_SIZE   = 40;

	logic clk;
	logic arst_n;

	ehct_frame_if  frames_ch ();
	ehct_result_if results_ch ();

	ethernet_header_classifier_tally DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.frames (frames_ch),
		.results(results_ch)
	);

	// predicted block state
	logic [ehct_pkg::COUNTER_WIDTH-1:0] seen_total;
	logic [ehct_pkg::COUNTER_WIDTH-1:0] class_tally [3];
	logic [ehct_pkg::COUNTER_WIDTH-1:0] proto_tally [5];
	logic [ehct_pkg::MAC_W-1:0]         mac_table [ehct_pkg::TABLE_ENTRIES];
	logic [ehct_pkg::TALLY_WIDTH-1:0]   mac_hits [ehct_pkg::TABLE_ENTRIES];
	int                                 macs_stored;

	ehct_pkg::result_t          expected_results [$];
	logic [ehct_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];
	logic [15:0]                known_types [5] = '{ehct_pkg::ETYPE_IPV4,
		ehct_pkg::ETYPE_IPV6, ehct_pkg::ETYPE_ARP, ehct_pkg::ETYPE_FLOW,
		ehct_pkg::ETYPE_MACSEC};

	int          mismatches = 0;
	int unsigned cycle_count = 0;
	bit          steady;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		results_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
	end

	// Look the address up among stored entries, else store it if there is room.
	function automatic logic [ehct_pkg::TALLY_WIDTH-1:0] tally_mac(
		input logic [ehct_pkg::MAC_W-1:0] mac, inout logic full);
		for (int i = 0; i < macs_stored; i++) begin
			if (mac_table[i] == mac) begin
				if (mac_hits[i] != '1)
					mac_hits[i]++;
				return mac_hits[i];
			end
		end
		if (macs_stored < ehct_pkg::TABLE_ENTRIES) begin
			mac_table[macs_stored] = mac;
			mac_hits[macs_stored]  = ehct_pkg::TALLY_WIDTH'(1);
			macs_stored++;
			return ehct_pkg::TALLY_WIDTH'(1);
		end
		full = 1'b1;
		return '0;
	endfunction

	function automatic ehct_pkg::result_t classify_frame(input ehct_pkg::frame_t f);
		ehct_pkg::result_t          r;
		logic [ehct_pkg::LEN_W-1:0] len;
		logic                       full;
		int                         ci;
		int                         pk;
		r = '0;
		r.protocol_kind = ehct_pkg::PROTO_NONE;
		full = 1'b0;
		if (seen_total != '1)
			seen_total++;
		r.total_count = seen_total;
		len = (f.frame_length > ehct_pkg::MAX_FRAME) ?
			ehct_pkg::LEN_W'(ehct_pkg::MAX_FRAME) : f.frame_length;
		if (len > ehct_pkg::HEADER_BYTES) begin
			if (f.ether_type >= ehct_pkg::ETH2_MIN_TYPE)
				r.frame_class = ehct_pkg::CLASS_ETH2;
			else if (f.ether_type <= ehct_pkg::LEN_MAX_TYPE)
				r.frame_class = ehct_pkg::CLASS_8023;
			else
				r.frame_class = ehct_pkg::CLASS_OTHER;
			ci = int'(r.frame_class) - 1;
			if (class_tally[ci] != '1)
				class_tally[ci]++;
			r.class_count = class_tally[ci];
			if (r.frame_class == ehct_pkg::CLASS_ETH2) begin
				case (f.ether_type)
					ehct_pkg::ETYPE_IPV4:   r.protocol_kind = ehct_pkg::PROTO_IPV4;
					ehct_pkg::ETYPE_IPV6:   r.protocol_kind = ehct_pkg::PROTO_IPV6;
					ehct_pkg::ETYPE_ARP:    r.protocol_kind = ehct_pkg::PROTO_ARP;
					ehct_pkg::ETYPE_FLOW:   r.protocol_kind = ehct_pkg::PROTO_FLOW;
					ehct_pkg::ETYPE_MACSEC: r.protocol_kind = ehct_pkg::PROTO_MACSEC;
					default:                r.protocol_kind = ehct_pkg::PROTO_NONE;
				endcase
				if (r.protocol_kind != ehct_pkg::PROTO_NONE) begin
					pk = int'(r.protocol_kind);
					if (proto_tally[pk] != '1)
						proto_tally[pk]++;
					r.protocol_count = proto_tally[pk];
				end
				r.payload_length = ehct_pkg::PAY_W'(len - ehct_pkg::HEADER_BYTES);
				r.src_multicast  = f.source_mac[40];
				r.dst_multicast  = f.dest_mac[40];
				// source first: equal addresses see the source's bump
				r.src_tally  = tally_mac(f.source_mac, full);
				r.dst_tally  = tally_mac(f.dest_mac, full);
				r.table_full = full;
			end
		end
		return r;
	endfunction

	function automatic ehct_pkg::frame_t make_frame(input int len,
		input logic [ehct_pkg::MAC_W-1:0] dst, input logic [ehct_pkg::MAC_W-1:0] src,
		input logic [15:0] etype);
		ehct_pkg::frame_t f;
		f.frame_length = ehct_pkg::LEN_W'(len);
		f.dest_mac     = dst;
		f.source_mac   = src;
		f.ether_type   = etype;
		return f;
	endfunction

	function automatic logic [ehct_pkg::MAC_W-1:0] random_mac();
		return {16'($urandom), $urandom};
	endfunction

	// Mostly reuse pool addresses so tallies climb; fresh ones fill the table.
	function automatic logic [ehct_pkg::MAC_W-1:0] pick_mac();
		if ($urandom_range(0, 99) < 85)
			return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
		return random_mac();
	endfunction

	function automatic ehct_pkg::frame_t random_frame();
		ehct_pkg::frame_t f;
		int               pick;
		pick = $urandom_range(0, 99);
		f.dest_mac   = pick_mac();
		f.source_mac = ($urandom_range(0, 9) == 0) ? f.dest_mac : pick_mac();
		if (pick < 70) begin
			f.ether_type = ($urandom_range(0, 2) != 0) ? known_types[$urandom_range(0, 4)]
				: 16'($urandom_range(ehct_pkg::ETH2_MIN_TYPE, 16'hFFFF));
			f.frame_length = ($urandom_range(0, 19) == 0) ? 12'($urandom_range(1519, 4095))
				: 12'($urandom_range(15, 1518));
		end else if (pick < 82) begin
			f.ether_type   = 16'($urandom_range(0, 16'h05FF));
			f.frame_length = 12'($urandom_range(15, ehct_pkg::MAX_FRAME));
		end else if (pick < 90) begin
			f.ether_type   = 16'($urandom);
			f.frame_length = 12'($urandom_range(0, ehct_pkg::HEADER_BYTES));
		end else begin
			f.frame_length = 12'($urandom);
			f.dest_mac     = random_mac();
			f.source_mac   = random_mac();
			f.ether_type   = 16'($urandom);
		end
		return f;
	endfunction

	task automatic send_frame(input ehct_pkg::frame_t f);
		while (!steady && $urandom_range(0, 99) < 28) begin
			frames_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frames_ch.valid <= 1'b1;
		frames_ch.data  <= f;
		do
			@(posedge clk);
		while (!frames_ch.ready);
		expected_results.push_back(classify_frame(f));
	endtask

	task automatic test_header_fields();
		logic [ehct_pkg::MAC_W-1:0] mac_a;
		logic [ehct_pkg::MAC_W-1:0] mac_b;
		mac_a = 48'h0A1B2C3D4E5F;
		mac_b = 48'h020000000042;
		send_frame(make_frame(0, mac_a, mac_b, ehct_pkg::ETYPE_IPV4));
		send_frame(make_frame(14, mac_a, mac_b, ehct_pkg::ETYPE_IPV4));
		send_frame(make_frame(15, mac_a, mac_b, ehct_pkg::ETH2_MIN_TYPE));
		send_frame(make_frame(64, mac_a, mac_b, ehct_pkg::LEN_MAX_TYPE));
		// type gap between length and type ranges
		send_frame(make_frame(64, mac_a, mac_b, 16'h05DD));
		send_frame(make_frame(64, mac_a, mac_b, 16'h05FF));
		send_frame(make_frame(64, mac_a, mac_b, 16'h0000));
		send_frame(make_frame(1514, mac_a, mac_b, ehct_pkg::ETYPE_IPV4));
		send_frame(make_frame(1514, mac_a, mac_b, ehct_pkg::ETYPE_IPV6));
		send_frame(make_frame(60, mac_b, mac_a, ehct_pkg::ETYPE_ARP));
		send_frame(make_frame(64, mac_a, mac_b, ehct_pkg::ETYPE_FLOW));
		send_frame(make_frame(100, mac_a, mac_b, ehct_pkg::ETYPE_MACSEC));
		send_frame(make_frame(ehct_pkg::MAX_FRAME, '0, '1, 16'hFFFF));
		// oversized lengths clamp to the maximum frame
		send_frame(make_frame(ehct_pkg::MAX_FRAME + 1, mac_a, mac_b, ehct_pkg::ETYPE_IPV4));
		send_frame(make_frame(4095, '1, '0, ehct_pkg::ETYPE_IPV6));
		send_frame(make_frame(4095, mac_a, mac_b, ehct_pkg::LEN_MAX_TYPE));
		// same address on both sides bumps one entry twice
		send_frame(make_frame(200, mac_a, mac_a, ehct_pkg::ETYPE_IPV4));
		send_frame(make_frame(200, mac_b, mac_b, ehct_pkg::ETYPE_ARP));
		send_frame(make_frame(80, 48'h01005E000001, 48'h333300000001,
			ehct_pkg::ETYPE_IPV6));
		send_frame(make_frame(15, 48'hFFFFFFFFFFFE, 48'h010000000000, 16'hFFFF));
		send_frame(make_frame(1, '1, '1, 16'h05DD));
	endtask

	task automatic test_back_to_back(input int count);
		steady = 1'b1;
		repeat (count)
			send_frame(random_frame());
		steady = 1'b0;
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count)
			send_frame(random_frame());
	endtask

	function automatic void check_field(input string fname, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		ehct_pkg::result_t want;
		ehct_pkg::result_t got;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			got = results_ch.data;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with no frame pending, expected none actual %h",
					$time, got);
			end else begin
				want = expected_results.pop_front();
				check_field("frame_class", 64'(want.frame_class), 64'(got.frame_class));
				check_field("protocol_kind", 64'(want.protocol_kind),
					64'(got.protocol_kind));
				check_field("payload_length", 64'(want.payload_length),
					64'(got.payload_length));
				check_field("src_multicast", 64'(want.src_multicast),
					64'(got.src_multicast));
				check_field("dst_multicast", 64'(want.dst_multicast),
					64'(got.dst_multicast));
				check_field("total_count", 64'(want.total_count), 64'(got.total_count));
				check_field("class_count", 64'(want.class_count), 64'(got.class_count));
				check_field("protocol_count", 64'(want.protocol_count),
					64'(got.protocol_count));
				check_field("src_tally", 64'(want.src_tally), 64'(got.src_tally));
				check_field("dst_tally", 64'(want.dst_tally), 64'(got.dst_tally));
				check_field("table_full", 64'(want.table_full), 64'(got.table_full));
			end
		end
	end

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		frames_ch.valid  = 1'b0;
		frames_ch.data   = '0;
		steady           = 1'b0;
		seen_total       = '0;
		class_tally      = '{default: '0};
		proto_tally      = '{default: '0};
		macs_stored      = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			mac_pool[i] = random_mac();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_fields();
		test_back_to_back(150);
		test_random_traffic(950);
		frames_ch.valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		// drain: catch any stray result after the last one
		repeat (160) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

/* ethernet_header_classifier_tally.f */
src/ehct_pkg.sv
src/ehct_ifs.sv
src/ethernet_header_classifier_tally.sv
test/tb_ethernet_header_classifier_tally.sv
